/* hw/rtl/assert_macros.svh */
// Assertion macros used by the servo speed calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SMSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition must never be seen.
`define SMSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* hw/rtl/smsc_pkg.sv */
// Shared types and constants of the servo speed calculator.
package smsc_pkg;

	localparam int SERVO_COUNT = 32;

	localparam int IDX_W   = 5;
	localparam int POS_W   = 10;
	localparam int OFF_W   = 11;
	localparam int TIME_W  = 16;
	localparam int SPEED_W = 10;
	localparam int QUO_W   = SPEED_W;
	localparam int PROD_W  = 20;

	localparam logic [POS_W-1:0]   POS_MAX      = 10'd1023;
	localparam logic [SPEED_W-1:0] SPEED_FACTOR = 10'd848;
	localparam logic [SPEED_W-1:0] SPEED_MAX    = 10'd1023;
	localparam logic [SPEED_W-1:0] SPEED_MIN    = 10'd26;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 16;

	// Item handed from the front part to the divider back part
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  fin;
		logic [POS_W-1:0]  travel;
		logic [TIME_W-1:0] step_time;
	} work_t;

	// Finished result
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [POS_W-1:0]   fin;
		logic [SPEED_W-1:0] speed;
	} res_t;

	// One stage of the restoring divider
	typedef struct packed {
		logic              sat;
		logic [TIME_W-1:0] rem;
		logic [QUO_W-1:0]  low;
		logic [QUO_W-1:0]  quo;
		logic [TIME_W-1:0] step_time;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  fin;
	} div_t;

endpackage

/* hw/rtl/smsc_fifo.sv */
// Small register-based FIFO used between and after the pipeline parts.
module smsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wp_q;
	logic [AW:0]      rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign rdata = mem_q[rp_q[AW-1:0]];

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q[AW-1:0]] <= wdata;
	end

endmodule

/* hw/rtl/smsc_front.sv */
// Front part: takes items, clamps the goal, keeps the per-servo position store.
module smsc_front #(
	parameter int SERVO_COUNT = smsc_pkg::SERVO_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              walk,
	input  logic                              push,
	output logic                              full,
	input  logic [smsc_pkg::IDX_W-1:0]        servo_index,
	input  logic [smsc_pkg::POS_W-1:0]        goal_position,
	input  logic signed [smsc_pkg::OFF_W-1:0] trim_offset,
	input  logic [smsc_pkg::POS_W-1:0]        measured_position,
	input  logic [smsc_pkg::TIME_W-1:0]       step_time,
	output logic                              wk_push,
	output smsc_pkg::work_t                   wk_data,
	input  logic                              wk_full
);

	localparam int AW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

	logic                         acc;
	logic                         adv;
	logic signed [smsc_pkg::OFF_W:0] sum;
	logic [smsc_pkg::POS_W-1:0]   fin;
	logic                         in_range;
	logic [AW-1:0]                addr;
	logic [smsc_pkg::POS_W-1:0]   wval;
	logic [smsc_pkg::POS_W-1:0]   ref_pos;

	logic [smsc_pkg::POS_W-1:0]   store_q [SERVO_COUNT];

	logic                         v_s1;
	logic [smsc_pkg::IDX_W-1:0]   idx_s1;
	logic [smsc_pkg::POS_W-1:0]   fin_s1;
	logic [smsc_pkg::POS_W-1:0]   meas_s1;
	logic [smsc_pkg::TIME_W-1:0]  time_s1;
	logic                         walk_s1;
	logic                         inr_s1;
	logic [smsc_pkg::POS_W-1:0]   rd_s1;

	// one-entry stage in front of the queue
	assign adv  = v_s1 && !wk_full;
	assign full = v_s1 && wk_full;
	assign acc  = push && !full;

	// goal plus signed offset, clamped to the position range
	assign sum = $signed({2'b00, goal_position}) + $signed({trim_offset[smsc_pkg::OFF_W-1],
		trim_offset});
	always_comb begin
		if (sum[smsc_pkg::OFF_W]) begin
			fin = '0;
		end else if (sum[smsc_pkg::OFF_W-1]) begin
			fin = smsc_pkg::POS_MAX;
		end else begin
			fin = sum[smsc_pkg::POS_W-1:0];
		end
	end

	assign in_range = (32'(servo_index) < SERVO_COUNT);
	assign addr     = AW'(servo_index);
	assign wval     = walk ? fin : measured_position;

	// position store: old entry is read and the new one written at the same edge
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= store_q[addr];
			if (in_range) store_q[addr] <= wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1  <= servo_index;
			fin_s1  <= fin;
			meas_s1 <= measured_position;
			time_s1 <= step_time;
			walk_s1 <= walk;
			inr_s1  <= in_range;
		end
	end

	// reference position and absolute travel
	always_comb begin
		if (!walk_s1) begin
			ref_pos = meas_s1;
		end else if (inr_s1) begin
			ref_pos = rd_s1;
		end else begin
			ref_pos = '0;
		end
	end

	assign wk_push           = adv;
	assign wk_data.idx       = idx_s1;
	assign wk_data.fin       = fin_s1;
	assign wk_data.travel    = (fin_s1 >= ref_pos) ? (fin_s1 - ref_pos) : (ref_pos - fin_s1);
	assign wk_data.step_time = time_s1;

endmodule

/* hw/rtl/smsc_back.sv */
// Back part: speed multiply, pipelined restoring divide, clamp and result queue.
module smsc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wk_empty,
	input  smsc_pkg::work_t                wk_data,
	output logic                           wk_pop,
	input  logic                           pop,
	output logic                           empty,
	output smsc_pkg::res_t                 res
);

	localparam int QW  = smsc_pkg::QUO_W;
	localparam int TW  = smsc_pkg::TIME_W;
	localparam int PW  = smsc_pkg::PROD_W;
	localparam int CW  = $clog2(smsc_pkg::OUT_DEPTH + 1);

	logic                         issue;
	logic                         pop_acc;
	logic [CW-1:0]                cred_q;

	logic                         v_s1;
	logic [smsc_pkg::IDX_W-1:0]   idx_s1;
	logic [smsc_pkg::POS_W-1:0]   fin_s1;
	logic [TW-1:0]                time_s1;
	logic [PW-1:0]                prod_s1;

	logic                         v_s2;
	smsc_pkg::div_t               div_s2;

	logic                         v_s3   [QW];
	smsc_pkg::div_t               div_s3 [QW];

	smsc_pkg::div_t               last;
	smsc_pkg::res_t               res_in;

	// issue only when a result slot is reserved for the item
	assign pop_acc = pop && !empty;
	assign issue   = !wk_empty && (cred_q < CW'(smsc_pkg::OUT_DEPTH));
	assign wk_pop  = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			case ({issue, pop_acc})
				2'b10:   cred_q <= cred_q + 1'b1;
				2'b01:   cred_q <= cred_q - 1'b1;
				default: cred_q <= cred_q;
			endcase
		end
	end

	// stage 1: constant multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= wk_data.idx;
		fin_s1  <= wk_data.fin;
		time_s1 <= wk_data.step_time;
		prod_s1 <= PW'(wk_data.travel) * PW'(smsc_pkg::SPEED_FACTOR);
	end

	// stage 2: saturation test, high part of the product is the first remainder
	always_ff @(posedge clk) begin
		div_s2.sat       <= (time_s1 == '0) || (TW'(prod_s1[PW-1:QW]) >= time_s1);
		div_s2.rem       <= TW'(prod_s1[PW-1:QW]);
		div_s2.low       <= prod_s1[QW-1:0];
		div_s2.quo       <= '0;
		div_s2.step_time <= time_s1;
		div_s2.idx       <= idx_s1;
		div_s2.fin       <= fin_s1;
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_iter
		smsc_pkg::div_t prv;
		smsc_pkg::div_t nxt;
		logic           prv_v;
		logic [TW:0]    rem_x;
		logic           ge;

		if (k == 0) begin : g_first
			assign prv   = div_s2;
			assign prv_v = v_s2;
		end else begin : g_next
			assign prv   = div_s3[k-1];
			assign prv_v = v_s3[k-1];
		end

		assign rem_x = {prv.rem, prv.low[QW-1]};
		assign ge    = (rem_x >= {1'b0, prv.step_time});

		// trial subtract, shift in the next dividend bit and the quotient bit
		always_comb begin
			nxt     = prv;
			nxt.rem = ge ? TW'(rem_x - {1'b0, prv.step_time}) : TW'(rem_x);
			nxt.low = {prv.low[QW-2:0], 1'b0};
			nxt.quo = {prv.quo[QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k] <= 1'b0;
			end else begin
				v_s3[k] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			div_s3[k] <= nxt;
		end
	end

	// final clamp to the speed range
	assign last       = div_s3[QW-1];
	assign res_in.idx = last.idx;
	assign res_in.fin = last.fin;
	always_comb begin
		if (last.sat) begin
			res_in.speed = smsc_pkg::SPEED_MAX;
		end else if (last.quo < smsc_pkg::SPEED_MIN) begin
			res_in.speed = smsc_pkg::SPEED_MIN;
		end else begin
			res_in.speed = last.quo;
		end
	end

	// result queue, never overfilled thanks to the reservation count
	smsc_fifo #(
		.WIDTH($bits(smsc_pkg::res_t)),
		.DEPTH(smsc_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v_s3[QW-1]),
		.wdata (res_in),
		.full  (),
		.pop   (pop),
		.rdata (res),
		.empty (empty)
	);

endmodule

/* hw/rtl/servo_move_speed_calc_core.sv */
// Top level of the servo goal and moving-speed calculator.
// Items pass the front stage, middle queue, multiply and saturation-test stages, the
// ten-stage restoring divider (one quotient bit per stage) and the result queue.
// Throughput: one item per cycle while full stays low; the divider never stalls.
// Reset clears all control state and walking mode; the position store holds
// no defined value until an item has written the entry.
`include "assert_macros.svh"

module servo_move_speed_calc_core #(
	parameter int SERVO_COUNT = smsc_pkg::SERVO_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              walking_mode,
	input  logic                              push,
	output logic                              full,
	input  logic [smsc_pkg::IDX_W-1:0]        servo_index,
	input  logic [smsc_pkg::POS_W-1:0]        goal_position,
	input  logic signed [smsc_pkg::OFF_W-1:0] trim_offset,
	input  logic [smsc_pkg::POS_W-1:0]        measured_position,
	input  logic [smsc_pkg::TIME_W-1:0]       step_time,
	input  logic                              pop,
	output logic                              empty,
	output logic [smsc_pkg::IDX_W-1:0]        servo_id_out,
	output logic [smsc_pkg::POS_W-1:0]        final_goal,
	output logic [smsc_pkg::SPEED_W-1:0]      move_speed
);

	logic            walking_mode_q;
	logic            mq_push;
	logic            mq_full;
	logic            mq_pop;
	logic            mq_empty;
	smsc_pkg::work_t mq_wdata;
	smsc_pkg::work_t mq_rdata;
	smsc_pkg::res_t  res;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			walking_mode_q <= walking_mode;
		end
	end

	smsc_front #(
		.SERVO_COUNT(SERVO_COUNT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.walk             (walking_mode_q),
		.push             (push),
		.full             (full),
		.servo_index      (servo_index),
		.goal_position    (goal_position),
		.trim_offset      (trim_offset),
		.measured_position(measured_position),
		.step_time        (step_time),
		.wk_push          (mq_push),
		.wk_data          (mq_wdata),
		.wk_full          (mq_full)
	);

	// queue between front and back
	smsc_fifo #(
		.WIDTH($bits(smsc_pkg::work_t)),
		.DEPTH(smsc_pkg::MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mq_push),
		.wdata (mq_wdata),
		.full  (mq_full),
		.pop   (mq_pop),
		.rdata (mq_rdata),
		.empty (mq_empty)
	);

	smsc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wk_empty(mq_empty),
		.wk_data (mq_rdata),
		.wk_pop  (mq_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign servo_id_out = res.idx;
	assign final_goal   = res.fin;
	assign move_speed   = res.speed;

	// the front never pushes into a full queue, the back never pops an empty one
	`SMSC_ASSERT_IMP(a_mid_no_ovf, clk, arst_n, mq_push, !mq_full)
	`SMSC_ASSERT_NEVER(a_mid_no_udf, clk, arst_n, mq_pop && mq_empty)

endmodule
